// ===== hdl/a85d_pkg.sv =====
// Shared types and constants for the ASCII85 stream decoder.
package a85d_pkg;

    localparam logic [7:0]  CHAR_BANG  = 8'h21;
    localparam logic [7:0]  CHAR_Z     = 8'h7A;
    localparam logic [7:0]  CHAR_TILDE = 8'h7E;
    localparam logic [7:0]  CHAR_GT    = 8'h3E;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;

    localparam logic [31:0] BASE       = 32'd85;
    localparam logic [31:0] PAD_MUL_1  = 32'd85;
    localparam logic [31:0] PAD_MUL_2  = 32'd7225;
    localparam logic [31:0] PAD_MUL_3  = 32'd614125;

    localparam logic [2:0]  GROUP_FULL = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        stream_end;
    } t_entry;

endpackage

// ===== hdl/a85d_front.sv =====
// Character classifier and group accumulator that queues decoded groups.
module a85d_front import a85d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic        r_await;
    logic        n_await;

    logic        accept;
    logic        blank;
    logic [31:0] digit;
    logic [31:0] acc_step;
    logic [31:0] pad_mul;
    logic [31:0] padded;

    assign accept  = i_valid & ~i_full;
    assign o_stall = i_full;

    always_comb begin
        blank    = i_char_code inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
        digit    = {24'd0, i_char_code} - {24'd0, CHAR_BANG};
        acc_step = r_acc * BASE + digit;
        case (r_count)
            3'd4: begin
                pad_mul = PAD_MUL_1;
            end
            3'd3: begin
                pad_mul = PAD_MUL_2;
            end
            default: begin
                pad_mul = PAD_MUL_3;
            end
        endcase
        padded = (r_acc + 32'd1) * pad_mul - 32'd1;
    end

    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_await = r_await;
        o_push  = 1'b0;
        o_entry = '0;
        if (accept && !blank) begin
            if (r_await) begin
                if (i_char_code == CHAR_GT) begin
                    n_await = 1'b0;
                end
            end else if (i_char_code == CHAR_TILDE) begin
                n_acc   = '0;
                n_count = '0;
                n_await = 1'b1;
                o_push  = 1'b1;
                o_entry.stream_end = 1'b1;
                if (r_count inside {[3'd2:3'd4]}) begin
                    o_entry.word   = padded;
                    o_entry.nbytes = r_count - 3'd1;
                end
            end else if (i_char_code == CHAR_Z && r_count == 3'd0) begin
                o_push         = 1'b1;
                o_entry.nbytes = 3'd4;
            end else if (r_count == GROUP_FULL) begin
                n_acc          = '0;
                n_count        = '0;
                o_push         = 1'b1;
                o_entry.word   = acc_step;
                o_entry.nbytes = 3'd4;
            end else begin
                n_acc   = acc_step;
                n_count = r_count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_await <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_await <= n_await;
        end
    end

endmodule

// ===== hdl/a85d_fifo.sv =====
// Short queue of decoded groups between the classifier and the byte emitter.
module a85d_fifo import a85d_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/a85d_back.sv =====
// Byte emitter that splits queued groups into output transactions.
module a85d_back import a85d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_head,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_stream_end
);

    logic        r_busy;
    logic [31:0] r_word;
    logic [2:0]  r_cnt;
    logic        r_bare;
    logic        r_end;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bv;
    logic        r_out_last;
    logic        r_out_end;

    logic        out_free;
    logic        emit;
    logic        cur_last;

    assign out_free = ~r_out_valid | ~i_stall;
    assign emit     = r_busy & out_free;
    assign cur_last = r_bare | (r_cnt == 3'd1);
    assign o_pop    = ~i_empty & (~r_busy | (emit & cur_last));

    assign o_valid      = r_out_valid;
    assign o_data_byte  = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_last       = r_out_last;
    assign o_stream_end = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && cur_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head.word;
            r_cnt  <= i_head.nbytes;
            r_bare <= (i_head.nbytes == 3'd0);
            r_end  <= i_head.stream_end;
        end else if (emit) begin
            r_word <= {r_word[23:0], 8'd0};
            r_cnt  <= r_cnt - 3'd1;
        end
        if (emit) begin
            r_out_byte <= r_bare ? 8'd0 : r_word[31:24];
            r_out_bv   <= ~r_bare;
            r_out_last <= cur_last;
            r_out_end  <= cur_last & r_end;
        end
    end

endmodule

// ===== hdl/ascii85_stream_decoder.sv =====
// ASCII85 stream decoder top level: one text character in, decoded bytes out.
// The decoder takes one character per cycle while o_stall is low. Whitespace
// and characters seen while waiting for the closing '>' produce no output. A
// complete group of five digits or a 'z' produces four output transactions,
// and a '~' produces one to three bytes or a bare end marker. The byte emitter
// delivers one transaction per cycle while i_stall is low, so a sustained
// stream of groups runs at the input rate, while a run of 'z' characters is
// held back by o_stall once the queue of FIFO_DEPTH pending groups has filled.
// With an empty queue, the result of a character is written into the queue,
// loaded into the byte emitter and registered at the output before it shows.
module ascii85_stream_decoder import a85d_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_stream_end,
    input  logic       i_stall
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry push_entry;
    t_entry head;

    a85d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    a85d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    a85d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_stream_end (o_stream_end)
    );

endmodule
